// ===== design/psm3_pkg.sv =====
// Shared constants, types and helper functions of the 3D point scatter matrix block.
package psm3_pkg;

	// Coordinate format and set size limit.
	localparam int IN_W       = 16;
	localparam int COORD_BITS = 16;
	localparam int MAX_POINTS = 65536;

	// Accumulator and result widths.
	localparam int SUM_W   = 33;
	localparam int SQ_W    = 47;
	localparam int CROSS_W = 48;
	localparam int PCNT_W  = 17;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);

	// Serial multiply-divide sizing: full product of two sum magnitudes.
	localparam int PROD_W = 2 * SUM_W;
	localparam int STEP_W = $clog2(PROD_W);

	// Number of unique matrix entries.
	localparam int N_ENT = 6;

	// Output stream packing.
	localparam int OUT_BITS   = 3 * SQ_W + 3 * CROSS_W + PCNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_DATA_W  = ((3 * IN_W + 7) / 8) * 8;

	// Matrix entry selector, also the order of the product accumulators.
	typedef enum logic [2:0] {
		SEL_XX,
		SEL_YY,
		SEL_ZZ,
		SEL_XY,
		SEL_XZ,
		SEL_YZ
	} prod_sel_t;

	// Controls from the sequencer to the accumulator bank.
	typedef struct packed {
		logic      capture;
		logic      mark_ovf;
		logic      clear;
		logic      mul_en;
		logic      add_en;
		prod_sel_t mul_sel;
		prod_sel_t rd_sel;
	} acc_ctrl_t;

	// Accumulator contents seen by the sequencer.
	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
		logic [CROSS_W-1:0]      rd;
		logic [CNT_W-1:0]        count;
		logic                    ovf;
	} acc_stat_t;

	// Takes the low COORD_BITS bits of an input coordinate as a signed value.
	function automatic logic signed [COORD_BITS-1:0] coord_ext(input logic [IN_W-1:0] v);
		logic [IN_W+COORD_BITS-1:0] wide;
		wide = {{COORD_BITS{1'b0}}, v};
		return wide[COORD_BITS-1:0];
	endfunction

	// Magnitude of a signed coordinate sum.
	function automatic logic [SUM_W-1:0] sum_mag(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] n;
		n = -v;
		return v[SUM_W-1] ? n : v;
	endfunction

endpackage

// ===== design/point_scatter_matrix_3d_top.sv =====
// Top level of the streaming 3D point scatter matrix block: sequencer and stream ports.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: px, py, pz; tlast: last_point
//   m_*      out        tdata: cov_xx..cov_yz, point_count; tuser: overflow
//
// A point is transferred, then the shared 16x16 multiplier and its accumulate stage cover
// the six products in turn. A point beyond the set limit is dropped and sets the overflow mark.
// The set end adds six passes of the serial multiply-divide unit (33 shift-add steps and
// 66 quotient bits each) before the result is registered.
// A finished result waits in the output register while the next set is accumulated; the
// block stalls only when a new set end is reached with that register still full.
// Reset clears every accumulator, the count, the overflow mark and the output valid.
module point_scatter_matrix_3d_top import psm3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // px, py, pz
	input  logic                  s_tlast,   // last_point
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // cov_xx, cov_yy, cov_zz, cov_xy, cov_xz,
	                                         // cov_yz, point_count, zero fill
	output logic                  m_tuser    // overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_FIN_GO,
		ST_FIN_WAIT,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [2:0]              step_q;
	logic [2:0]              fin_e_q;
	logic                    last_q;
	logic [CROSS_W-1:0]      res_q [N_ENT];
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic                    m_tuser_q;
	acc_ctrl_t               ctrl;
	acc_stat_t               stat;
	logic                    s_xfer;
	logic                    at_max;
	logic                    out_free;
	logic                    md_start;
	logic                    md_done;
	logic signed [SUM_W-1:0] md_a, md_b;
	logic [CROSS_W-1:0]      md_q;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign at_max   = (stat.count == CNT_W'(MAX_POINTS));
	assign out_free = !m_tvalid_q || m_tready;
	assign md_start = (state_q == ST_FIN_GO);

	// Accumulator control for each state.
	always_comb begin
		ctrl          = '0;
		ctrl.mul_sel  = SEL_XX;
		ctrl.rd_sel   = prod_sel_t'(fin_e_q);
		unique case (state_q)
			ST_IDLE: begin
				ctrl.capture  = s_xfer && !at_max;
				ctrl.mark_ovf = s_xfer && at_max;
			end
			ST_ACC: begin
				ctrl.mul_en  = (step_q < 3'(N_ENT));
				ctrl.mul_sel = prod_sel_t'(step_q);
				ctrl.add_en  = (step_q != 3'd0);
				ctrl.rd_sel  = prod_sel_t'(step_q - 3'd1);
			end
			ST_OUT: begin
				ctrl.clear = out_free;
			end
			default: begin
			end
		endcase
	end

	// Operands of the correction term for the entry being finished.
	always_comb begin
		unique case (prod_sel_t'(fin_e_q))
			SEL_XX:  begin md_a = stat.sx; md_b = stat.sx; end
			SEL_YY:  begin md_a = stat.sy; md_b = stat.sy; end
			SEL_ZZ:  begin md_a = stat.sz; md_b = stat.sz; end
			SEL_XY:  begin md_a = stat.sx; md_b = stat.sy; end
			SEL_XZ:  begin md_a = stat.sx; md_b = stat.sz; end
			SEL_YZ:  begin md_a = stat.sy; md_b = stat.sz; end
			default: begin md_a = stat.sx; md_b = stat.sx; end
		endcase
	end

	psm3_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.px     (s_tdata[IN_W-1:0]),
		.py     (s_tdata[2*IN_W-1:IN_W]),
		.pz     (s_tdata[3*IN_W-1:2*IN_W]),
		.stat   (stat)
	);

	psm3_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (md_a),
		.b      (md_b),
		.c      (stat.count),
		.done   (md_done),
		.q      (md_q)
	);

	// Sequencer, result staging and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			fin_e_q    <= '0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						last_q  <= s_tlast;
						step_q  <= '0;
						fin_e_q <= '0;
						if (at_max) begin
							state_q <= s_tlast ? ST_FIN_GO : ST_IDLE;
						end else begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (step_q == 3'(N_ENT)) begin
						state_q <= last_q ? ST_FIN_GO : ST_IDLE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_FIN_GO: begin
					state_q <= ST_FIN_WAIT;
				end
				ST_FIN_WAIT: begin
					if (md_done) begin
						res_q[fin_e_q] <= stat.rd - md_q;
						if (fin_e_q == 3'(N_ENT - 1)) begin
							state_q <= ST_OUT;
						end else begin
							fin_e_q <= fin_e_q + 3'd1;
							state_q <= ST_FIN_GO;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= OUT_DATA_W'({PCNT_W'(stat.count),
							res_q[5], res_q[4], res_q[3],
							res_q[2][SQ_W-1:0], res_q[1][SQ_W-1:0], res_q[0][SQ_W-1:0]});
						m_tuser_q  <= stat.ovf;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The accumulators are cleared only as a result is loaded for transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (m_tvalid && stat.count == '0 && !stat.ovf))
		else $error("accumulator clear without a loaded result");

	// The count never passes the set limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(MAX_POINTS))
		else $error("point count beyond the set limit");

	// A point is dropped only at the limit; it sets the overflow mark and leaves the count as it is.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mark_ovf |=> (stat.ovf && $stable(stat.count)))
		else $error("dropped point changed the count");

	// The divide unit reports completion only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_FIN_WAIT))
		else $error("divide completion outside the wait state");

endmodule

// ===== design/psm3_acc.sv =====
// Accumulator bank with one shared coordinate multiplier for the scatter matrix block.
module psm3_acc import psm3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  acc_ctrl_t         ctrl,
	input  logic [IN_W-1:0]   px,
	input  logic [IN_W-1:0]   py,
	input  logic [IN_W-1:0]   pz,
	output acc_stat_t         stat
);

	logic signed [COORD_BITS-1:0]   x_q, y_q, z_q;
	logic signed [COORD_BITS-1:0]   mul_a, mul_b;
	logic signed [2*COORD_BITS-1:0] prod_s1;
	logic signed [SUM_W-1:0]        sx_q, sy_q, sz_q;
	logic [CROSS_W-1:0]             acc_q [N_ENT];
	logic [CROSS_W-1:0]             acc_rd;
	logic [CNT_W-1:0]               count_q;
	logic                           ovf_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctrl.mul_sel)
			SEL_XX:  begin mul_a = x_q; mul_b = x_q; end
			SEL_YY:  begin mul_a = y_q; mul_b = y_q; end
			SEL_ZZ:  begin mul_a = z_q; mul_b = z_q; end
			SEL_XY:  begin mul_a = x_q; mul_b = y_q; end
			SEL_XZ:  begin mul_a = x_q; mul_b = z_q; end
			SEL_YZ:  begin mul_a = y_q; mul_b = z_q; end
			default: begin mul_a = x_q; mul_b = x_q; end
		endcase
	end

	// Single read port of the product accumulators. The diagonal entries are kept at the
	// cross width; their low bits wrap exactly as a narrower register would.
	always_comb begin
		case (ctrl.rd_sel)
			SEL_XX:  acc_rd = acc_q[0];
			SEL_YY:  acc_rd = acc_q[1];
			SEL_ZZ:  acc_rd = acc_q[2];
			SEL_XY:  acc_rd = acc_q[3];
			SEL_XZ:  acc_rd = acc_q[4];
			SEL_YZ:  acc_rd = acc_q[5];
			default: acc_rd = '0;
		endcase
	end

	// Point capture and the registered product of the multiplier stage.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			x_q <= coord_ext(px);
			y_q <= coord_ext(py);
			z_q <= coord_ext(pz);
		end
		if (ctrl.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	// Running sums, product accumulators, point count and overflow mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			for (int i = 0; i < N_ENT; i++) begin
				acc_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			for (int i = 0; i < N_ENT; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (ctrl.capture) begin
				sx_q    <= sx_q + SUM_W'(coord_ext(px));
				sy_q    <= sy_q + SUM_W'(coord_ext(py));
				sz_q    <= sz_q + SUM_W'(coord_ext(pz));
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.mark_ovf) begin
				ovf_q <= 1'b1;
			end
			if (ctrl.add_en) begin
				acc_q[ctrl.rd_sel] <= acc_rd + CROSS_W'(prod_s1);
			end
		end
	end

	assign stat.sx    = sx_q;
	assign stat.sy    = sy_q;
	assign stat.sz    = sz_q;
	assign stat.rd    = acc_rd;
	assign stat.count = count_q;
	assign stat.ovf   = ovf_q;

endmodule

// ===== design/psm3_muldiv.sv =====
// Bit-serial signed multiply then divide unit: truncated (a * b) / c.
module psm3_muldiv import psm3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] a,
	input  logic signed [SUM_W-1:0] b,
	input  logic [CNT_W-1:0]        c,
	output logic                    done,
	output logic [CROSS_W-1:0]      q
);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_t;

	md_state_t           state_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [SUM_W-1:0]    mplier_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    div_q;
	logic [CROSS_W-1:0]  quo_q;
	logic                neg_q;
	logic [CNT_W:0]      rem_try;
	logic [CNT_W:0]      rem_sub;
	logic                fits;

	// Restoring division step: bring down the next product bit and try the divisor.
	assign rem_try = {rem_q, prod_q[PROD_W-1]};
	assign rem_sub = rem_try - {1'b0, div_q};
	assign fits    = (rem_try >= {1'b0, div_q});

	// Sequencer: one shift-add per cycle, then one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						mcand_q  <= PROD_W'(sum_mag(a));
						mplier_q <= sum_mag(b);
						prod_q   <= '0;
						neg_q    <= a[SUM_W-1] ^ b[SUM_W-1];
						div_q    <= c;
						cnt_q    <= '0;
						state_q  <= MD_MUL;
					end
				end
				MD_MUL: begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
					if (cnt_q == STEP_W'(SUM_W - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= '0;
						state_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				MD_DIV: begin
					rem_q  <= fits ? rem_sub[CNT_W-1:0] : rem_try[CNT_W-1:0];
					quo_q  <= {quo_q[CROSS_W-2:0], fits};
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					if (cnt_q == STEP_W'(PROD_W - 1)) begin
						state_q <= MD_DONE;
					end else begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				MD_DONE: begin
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// Signed result; a zero divisor gives a zero quotient.
	assign done = (state_q == MD_DONE);
	assign q    = (div_q == '0) ? '0 : (neg_q ? -quo_q : quo_q);

endmodule
